### hw/rtl/midi_rsp_pkg.sv
// Package for the MIDI running-status parser: payload structs, parser state
// type, status byte constants and the data-length lookup. No dependencies.
`timescale 1ns / 1ps

package midi_rsp_pkg;

  // Status byte codes
  localparam logic [7:0] StatusBit    = 8'h80;
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [7:0] RealtimeBase = 8'hF8;
  localparam logic [7:0] TimeCodeQtr  = 8'hF1;
  localparam logic [7:0] SongPosition = 8'hF2;
  localparam logic [7:0] SongSelect   = 8'hF3;
  localparam logic [6:0] DataMask     = 7'h7F;

  // Message lengths, status included
  localparam logic [1:0] LenStatusOnly = 2'd1;
  localparam logic [1:0] LenOneData    = 2'd2;
  localparam logic [1:0] LenTwoData    = 2'd3;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       packet_end;
  } midi_in_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] msg_length;
  } midi_out_t;

  typedef struct packed {
    logic [7:0] running_status;
    logic       skipping_sysex;
    logic [7:0] current_status;
    logic [1:0] bytes_needed;
    logic [1:0] bytes_taken;
    logic [6:0] first_data;
  } parse_state_t;

  // Number of data bytes that follow a status byte
  function automatic logic [1:0] data_count(input logic [7:0] s);
    logic [1:0] cnt;
    begin
      case (s[7:4])
        4'h8, 4'h9, 4'hA, 4'hB, 4'hE: cnt = 2'd2;
        4'hC, 4'hD: cnt = 2'd1;
        4'hF: begin
          if (s inside {TimeCodeQtr, SongSelect}) begin
            cnt = 2'd1;
          end else if (s == SongPosition) begin
            cnt = 2'd2;
          end else begin
            cnt = 2'd0;
          end
        end
        default: cnt = 2'd0;
      endcase
      return cnt;
    end
  endfunction

endpackage

### hw/rtl/midi_running_status_parser_unit.sv
// Top level of the MIDI running-status parser: input and output registers
// around the parser core. Depends on midi_rsp_pkg and midi_rsp_core.
`timescale 1ns / 1ps

// MIDI running-status parser. Takes one raw MIDI byte per transaction, with a
// flag on the last byte of each packet, and gives one transaction per complete
// message: status byte, up to two 7-bit data bytes (0 when absent) and the
// message length in bytes. Running status carries across packets; a packet end
// drops a partial message or an open SysEx skip. Bytes that complete no message
// (data bytes collected, SysEx contents, data with no running status) produce
// no output transaction. Throughput is one byte per clock cycle unless an
// untaken result stalls a byte that yields a message: the parser state is
// updated by one pass of compare-and-select logic between the input and
// output registers. The output register frees itself when its transaction
// is taken, so input is still accepted while a result waits, as long as the
// result register is drained or the byte yields no message. No configuration.
module midi_running_status_parser_unit import midi_rsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  midi_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output midi_out_t out_data_o
);

  logic      in_valid_q;
  midi_in_t  in_data_q;
  logic      out_valid_q;
  midi_out_t out_data_q;

  logic      advance;
  logic      res_valid;
  midi_out_t res;

  // The registered byte moves through the core when the result slot is free
  // (empty or being taken this cycle); bytes with no result always move.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i || !res_valid);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  midi_rsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_data_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/midi_rsp_core.sv
// Parser core: state registers and the single-pass next-state / message logic.
// Depends on midi_rsp_pkg.
`timescale 1ns / 1ps

module midi_rsp_core import midi_rsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,       // consume byte_i this cycle
  input  midi_in_t  byte_i,
  output logic      res_valid_o,  // byte_i completes a message
  output midi_out_t res_o
);

  parse_state_t state_q, state_d;

  always_comb begin
    logic [7:0] b;
    logic [6:0] d;
    logic [1:0] cnt;
    logic [1:0] taken;
    b     = byte_i.midi_byte;
    d     = b[6:0] & DataMask;
    cnt   = 2'd0;
    taken = 2'd0;

    state_d     = state_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (state_q.bytes_needed != 2'd0) begin
      // Collecting data: any byte counts, top bit dropped
      taken = state_q.bytes_taken + 2'd1;
      state_d.bytes_taken = taken;
      if (state_q.bytes_needed == 2'd1) begin
        res_valid_o = 1'b1;
        res_o = '{status_byte: state_q.current_status, data_one: d,
                  data_two: 7'd0, msg_length: LenOneData};
        state_d.bytes_needed = 2'd0;
        state_d.bytes_taken  = 2'd0;
      end else if (taken >= 2'd2) begin
        res_valid_o = 1'b1;
        res_o = '{status_byte: state_q.current_status, data_one: state_q.first_data,
                  data_two: d, msg_length: LenTwoData};
        state_d.bytes_needed = 2'd0;
        state_d.bytes_taken  = 2'd0;
      end else begin
        state_d.first_data = d;
      end
    end else if (state_q.skipping_sysex) begin
      if (b == SysexEnd) begin
        state_d.skipping_sysex = 1'b0;
      end
    end else if ((b & StatusBit) != 8'd0) begin
      if (b == SysexStart) begin
        state_d.skipping_sysex = 1'b1;
      end else begin
        // Channel status sets running status, system common clears it
        if (b < RealtimeBase) begin
          state_d.running_status = (b < SysexStart) ? b : 8'd0;
        end
        cnt = data_count(b);
        if (cnt == 2'd0) begin
          res_valid_o = 1'b1;
          res_o = '{status_byte: b, data_one: 7'd0, data_two: 7'd0,
                    msg_length: LenStatusOnly};
        end else begin
          state_d.current_status = b;
          state_d.bytes_needed   = cnt;
          state_d.bytes_taken    = 2'd0;
        end
      end
    end else if (state_q.running_status != 8'd0) begin
      // Data byte under running status
      cnt = data_count(state_q.running_status);
      state_d.current_status = state_q.running_status;
      if (cnt == 2'd1) begin
        res_valid_o = 1'b1;
        res_o = '{status_byte: state_q.running_status, data_one: d,
                  data_two: 7'd0, msg_length: LenOneData};
      end else if (cnt == 2'd2) begin
        state_d.first_data   = d;
        state_d.bytes_needed = 2'd2;
        state_d.bytes_taken  = 2'd1;
      end else begin
        res_valid_o = 1'b1;
        res_o = '{status_byte: state_q.running_status, data_one: 7'd0,
                  data_two: 7'd0, msg_length: LenStatusOnly};
      end
    end

    // Packet end drops partial messages and open SysEx
    if (byte_i.packet_end) begin
      state_d.bytes_needed   = 2'd0;
      state_d.bytes_taken    = 2'd0;
      state_d.skipping_sysex = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule
